>>> src/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

    localparam int ByteW = 8;
    localparam int CpW   = 21;
    localparam int LenW  = 3;
    localparam int PendW = 2;

    localparam logic [4:0] LEAD4_TAG = 5'h1e;
    localparam logic [3:0] LEAD3_TAG = 4'h0e;
    localparam logic [2:0] LEAD2_TAG = 3'h06;

    localparam logic [ByteW-1:0] LEAD4_MASK = 8'hf0;
    localparam logic [ByteW-1:0] LEAD3_MASK = 8'he0;
    localparam logic [ByteW-1:0] LEAD2_MASK = 8'hc0;
    localparam logic [ByteW-1:0] CONT_MASK  = 8'h80;

    localparam logic [LenW-1:0] LEN1 = 3'd1;
    localparam logic [LenW-1:0] LEN2 = 3'd2;
    localparam logic [LenW-1:0] LEN3 = 3'd3;
    localparam logic [LenW-1:0] LEN4 = 3'd4;

    typedef struct packed {
        logic [ByteW-1:0] byte_in;
        logic             end_of_string;
    } item_t;

    typedef struct packed {
        logic [CpW-1:0]  code_point;
        logic [LenW-1:0] seq_length;
        logic            truncated;
    } result_t;

endpackage

>>> src/utf8sd_in_reg.sv
// Input register stage holding one accepted request.
module utf8sd_in_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  utf8sd_pkg::item_t in_item,
    output logic             item_valid,
    output utf8sd_pkg::item_t item,
    input  logic             advance
);

    logic              valid_reg;
    logic              valid_next;
    utf8sd_pkg::item_t item_reg;

    // take a new request when the slot is empty or is moving on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> src/utf8sd_step.sv
// Decoder state and the per-byte update that forms at most one result.
module utf8sd_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  utf8sd_pkg::item_t   item,
    output logic                res_valid,
    output utf8sd_pkg::result_t res
);

    logic [utf8sd_pkg::CpW-1:0]   acc_reg;
    logic [utf8sd_pkg::CpW-1:0]   acc_next;
    logic [utf8sd_pkg::PendW-1:0] pend_reg;
    logic [utf8sd_pkg::PendW-1:0] pend_next;
    logic [utf8sd_pkg::LenW-1:0]  cur_reg;
    logic [utf8sd_pkg::LenW-1:0]  cur_next;

    logic [utf8sd_pkg::ByteW-1:0] b;
    logic [utf8sd_pkg::LenW-1:0]  lead_len;
    logic [utf8sd_pkg::ByteW-1:0] lead_mask;
    logic [utf8sd_pkg::CpW-1:0]   shifted;
    logic [utf8sd_pkg::PendW-1:0] pend_dec;

    assign b = item.byte_in;

    always_comb
    begin
        priority if (b[7:3] == utf8sd_pkg::LEAD4_TAG)
        begin
            lead_len  = utf8sd_pkg::LEN4;
            lead_mask = utf8sd_pkg::LEAD4_MASK;
        end
        else if (b[7:4] == utf8sd_pkg::LEAD3_TAG)
        begin
            lead_len  = utf8sd_pkg::LEN3;
            lead_mask = utf8sd_pkg::LEAD3_MASK;
        end
        else if (b[7:5] == utf8sd_pkg::LEAD2_TAG)
        begin
            lead_len  = utf8sd_pkg::LEN2;
            lead_mask = utf8sd_pkg::LEAD2_MASK;
        end
        else
        begin
            lead_len  = utf8sd_pkg::LEN1;
            lead_mask = '0;
        end
    end

    // merge all eight bits, continuation marker or not
    assign shifted  = {acc_reg[utf8sd_pkg::CpW-7:0], 6'b0}
                    | {{(utf8sd_pkg::CpW-utf8sd_pkg::ByteW){1'b0}},
                       b ^ utf8sd_pkg::CONT_MASK};
    assign pend_dec = pend_reg - 2'd1;

    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        cur_next  = cur_reg;
        res_valid = 1'b0;
        res       = '0;
        if (fire)
        begin
            if (pend_reg == '0)
            begin
                if (lead_len == utf8sd_pkg::LEN1)
                begin
                    res_valid      = 1'b1;
                    res.code_point = {{(utf8sd_pkg::CpW-utf8sd_pkg::ByteW){1'b0}}, b};
                    res.seq_length = utf8sd_pkg::LEN1;
                    acc_next       = '0;
                    cur_next       = utf8sd_pkg::LEN1;
                end
                else if (item.end_of_string)
                begin
                    res_valid      = 1'b1;
                    res.seq_length = utf8sd_pkg::LEN1;
                    res.truncated  = 1'b1;
                    acc_next       = '0;
                    cur_next       = utf8sd_pkg::LEN1;
                end
                else
                begin
                    acc_next  = {{(utf8sd_pkg::CpW-utf8sd_pkg::ByteW){1'b0}}, b ^ lead_mask};
                    cur_next  = lead_len;
                    pend_next = utf8sd_pkg::PendW'(lead_len - 3'd1);
                end
            end
            else
            begin
                acc_next  = shifted;
                pend_next = pend_dec;
                if (pend_dec == '0)
                begin
                    res_valid      = 1'b1;
                    res.code_point = shifted;
                    res.seq_length = cur_reg;
                    acc_next       = '0;
                    cur_next       = utf8sd_pkg::LEN1;
                end
                else if (item.end_of_string)
                begin
                    // report the bytes received so far and drop the partial value
                    res_valid      = 1'b1;
                    res.seq_length = cur_reg - {1'b0, pend_dec};
                    res.truncated  = 1'b1;
                    acc_next       = '0;
                    pend_next      = '0;
                    cur_next       = utf8sd_pkg::LEN1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= '0;
            cur_reg  <= utf8sd_pkg::LEN1;
        end
        else
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            cur_reg  <= cur_next;
        end
    end

endmodule

>>> src/utf8_stream_decoder_unit.sv
// Top level: input register, decode step and result register.
// A final byte waits in the input register; its result is held in the result register.
// Throughput: one byte per cycle unless the master stalls, set by the combinational
// decode between the two registers; a byte ending no sequence yields no result but leaves.
// Reset (rst_n low, asynchronous) empties both registers and returns the decoder to idle.
module utf8_stream_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] seq_length
    output logic [0:0]  m_axis_tuser    // [0] truncated
);

    utf8sd_pkg::item_t   in_item;
    utf8sd_pkg::item_t   item;
    utf8sd_pkg::result_t res;
    utf8sd_pkg::result_t res_reg;
    logic                item_valid;
    logic                advance;
    logic                fire;
    logic                res_valid;
    logic                out_valid_reg;
    logic                out_valid_next;

    assign in_item.byte_in       = s_axis_tdata;
    assign in_item.end_of_string = s_axis_tlast;

    // move the held byte on when the result slot is free or being drained
    assign advance = !out_valid_reg || m_axis_tready;
    assign fire    = item_valid && advance;

    utf8sd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    utf8sd_step u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = fire && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {res_reg.seq_length, res_reg.code_point};
    assign m_axis_tuser[0] = res_reg.truncated;

endmodule

>>> verif/utf8_stream_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 stream decoder, with a code point scoreboard.
module utf8_stream_decoder_unit_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 1950;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    // Tracks the decoder state and holds the code points still owed by the block.
    class code_point_board;
        logic [utf8sd_pkg::CpW-1:0]   acc;
        logic [utf8sd_pkg::PendW-1:0] left;
        logic [utf8sd_pkg::LenW-1:0]  seq_len;
        utf8sd_pkg::result_t          owed_q[$];
        int                           mismatches;
        int                           chars_seen;
        int                           cuts_seen;

        function new();
            mismatches = 0;
            chars_seen = 0;
            cuts_seen  = 0;
            go_idle();
        endfunction

        function void go_idle();
            acc     = '0;
            left    = '0;
            seq_len = utf8sd_pkg::LEN1;
        endfunction

        function void owe(logic [utf8sd_pkg::CpW-1:0] cp, logic [utf8sd_pkg::LenW-1:0] len,
                          logic cut);
            utf8sd_pkg::result_t r;
            r.code_point = cp;
            r.seq_length = len;
            r.truncated  = cut;
            owed_q.push_back(r);
            go_idle();
        endfunction

        function void note_byte(utf8sd_pkg::item_t it);
            logic [utf8sd_pkg::ByteW-1:0] b;
            b = it.byte_in;
            if (left == 0)
            begin
                if (b[7:3] == utf8sd_pkg::LEAD4_TAG)
                begin
                    acc     = {13'b0, b ^ utf8sd_pkg::LEAD4_MASK};
                    seq_len = utf8sd_pkg::LEN4;
                end
                else if (b[7:4] == utf8sd_pkg::LEAD3_TAG)
                begin
                    acc     = {13'b0, b ^ utf8sd_pkg::LEAD3_MASK};
                    seq_len = utf8sd_pkg::LEN3;
                end
                else if (b[7:5] == utf8sd_pkg::LEAD2_TAG)
                begin
                    acc     = {13'b0, b ^ utf8sd_pkg::LEAD2_MASK};
                    seq_len = utf8sd_pkg::LEN2;
                end
                else
                begin
                    // anything that is not a lead passes straight through
                    owe({13'b0, b}, utf8sd_pkg::LEN1, 1'b0);
                    return;
                end
                left = utf8sd_pkg::PendW'(seq_len - utf8sd_pkg::LEN1);
                if (it.end_of_string)
                    owe('0, utf8sd_pkg::LEN1, 1'b1);
            end
            else
            begin
                // merge all eight bits, continuation or not; wrap to 21 bits
                acc  = {acc[utf8sd_pkg::CpW-7:0], 6'b0}
                     | {13'b0, b ^ utf8sd_pkg::CONT_MASK};
                left = left - 1'b1;
                if (left == 0)
                    owe(acc, seq_len, 1'b0);
                else if (it.end_of_string)
                    owe('0, seq_len - utf8sd_pkg::LenW'(left), 1'b1);
            end
        endfunction

        function void check_result(utf8sd_pkg::result_t got);
            utf8sd_pkg::result_t want;
            if (owed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: cp=%06h len=%0d cut=%0b",
                             got.code_point, got.seq_length, got.truncated);
                return;
            end
            want = owed_q.pop_front();
            chars_seen++;
            if (got.truncated)
                cuts_seen++;
            if (got.code_point !== want.code_point || got.seq_length !== want.seq_length ||
                got.truncated !== want.truncated)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: want cp=%06h len=%0d cut=%0b, got cp=%06h len=%0d cut=%0b",
                             want.code_point, want.seq_length, want.truncated,
                             got.code_point, got.seq_length, got.truncated);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    code_point_board board;
    int              src_idle_pct;
    int              sink_stall_pct;
    int              bytes_sent;
    int              cycle_count = 0;

    utf8_stream_decoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("utf8_stream_decoder_unit_test: errors");
            $finish;
        end
    end

    // Receiver: check each accepted result and stall at random.
    always @(posedge clk)
    begin
        utf8sd_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.code_point = m_axis_tdata[20:0];
            got.seq_length = m_axis_tdata[23:21];
            got.truncated  = m_axis_tuser[0];
            board.check_result(got);
        end
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hold the request until accepted; leave valid high for a back-to-back byte.
    task automatic push_byte(input utf8sd_pkg::item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.byte_in;
        s_axis_tlast  <= it.end_of_string;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_byte(it);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.owed_q.size() != 0);
    endtask

    // One string of mostly well-formed characters; some end mid-character.
    task automatic send_string();
        int                n_chars;
        int                k;
        int                j;
        int                len;
        int                nb;
        bit                cut;
        utf8sd_pkg::item_t it;
        logic [7:0]        seq [4];
        n_chars = $urandom_range(1, 8);
        cut     = ($urandom_range(99) < 15);
        for (k = 0; k < n_chars; k++)
        begin
            len = $urandom_range(1, 4);
            case (len)
                1: if ($urandom_range(99) < 70)
                       seq[0] = 8'($urandom_range(0, 127));
                   else if ($urandom_range(1))
                       seq[0] = {2'b10, 6'($urandom)};
                   else
                       seq[0] = {5'b11111, 3'($urandom)};
                2: seq[0] = {utf8sd_pkg::LEAD2_TAG, 5'($urandom)};
                3: seq[0] = {utf8sd_pkg::LEAD3_TAG, 4'($urandom)};
                default: seq[0] = {utf8sd_pkg::LEAD4_TAG, 3'($urandom)};
            endcase
            for (j = 1; j < 4; j++)
                seq[j] = ($urandom_range(99) < 90) ? {2'b10, 6'($urandom)} : 8'($urandom);
            nb = (cut && len > 1 && k == n_chars - 1) ? $urandom_range(1, len - 1) : len;
            for (j = 0; j < nb; j++)
            begin
                it.byte_in       = seq[j];
                it.end_of_string = (k == n_chars - 1) && (j == nb - 1);
                push_byte(it);
            end
        end
    endtask

    initial
    begin
        logic [8:0]        opening [25];
        int                src_plan  [4];
        int                sink_plan [4];
        int                ph;
        int                i;
        utf8sd_pkg::item_t it;

        opening = '{
            {8'h00, 1'b0}, {8'h7f, 1'b0},
            {8'hc3, 1'b0}, {8'h41, 1'b0},
            {8'hef, 1'b0}, {8'hbf, 1'b0}, {8'hbf, 1'b0},
            {8'hf0, 1'b0}, {8'h9f, 1'b0}, {8'h98, 1'b0}, {8'h80, 1'b0},
            {8'hf7, 1'b0}, {8'hff, 1'b0}, {8'hff, 1'b0}, {8'hff, 1'b0},
            {8'h80, 1'b0}, {8'hff, 1'b0}, {8'hf8, 1'b0},
            {8'he2, 1'b1},
            {8'hf0, 1'b0}, {8'h9f, 1'b0}, {8'h98, 1'b1},
            {8'hc2, 1'b0}, {8'ha9, 1'b1},
            {8'h41, 1'b1}
        };
        src_plan  = '{0, 61, 0, 17};
        sink_plan = '{0, 0, 61, 17};

        board          = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        bytes_sent     = 0;
        rst_n          = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 25; i++)
            push_byte(utf8sd_pkg::item_t'(opening[i]));
        wait_drained();

        for (ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   = src_plan[ph];
            sink_stall_pct = sink_plan[ph];
            while (bytes_sent < 25 + (ph + 1) * RANDOM_BYTES / 4)
            begin
                if ($urandom_range(99) < 10)
                begin
                    it.byte_in       = 8'($urandom);
                    it.end_of_string = 1'($urandom);
                    push_byte(it);
                end
                else
                    send_string();
            end
            // hold off until every owed result is back before changing pace
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d bytes in four pacing phases; checked %0d results, %0d cut short",
                 bytes_sent, board.chars_seen, board.cuts_seen);
        if (board.mismatches == 0 && board.owed_q.size() == 0)
            $display("utf8_stream_decoder_unit_test: clean");
        else
        begin
            $display("%0d mismatches, %0d results outstanding",
                     board.mismatches, board.owed_q.size());
            $display("utf8_stream_decoder_unit_test: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/utf8sd_pkg.sv
src/utf8sd_in_reg.sv
src/utf8sd_step.sv
src/utf8_stream_decoder_unit.sv
verif/utf8_stream_decoder_unit_test.sv
